/* hdl/assert_macros.svh */
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge outside reset.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property that must also hold while reset is high.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/f32f16_pkg.sv */
// ----------------------------------------------------------------------------
// Float32 to float16 package
// Shared constants and types for the single to half precision converter.
// ----------------------------------------------------------------------------
package f32f16_pkg;

  localparam int unsigned DEPTH_DEFAULT = 3;

  localparam logic [15:0] HALF_INF  = 16'h7C00;
  localparam logic [15:0] HALF_ONE  = 16'h0400;
  localparam logic [9:0]  MANT_SAT  = 10'd1023;

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_DENORM,
    CLS_NORMAL,
    CLS_OVF,
    CLS_SPECIAL
  } cls_t;

endpackage

/* hdl/float32_to_float16.sv */
// ----------------------------------------------------------------------------
// Float32 to float16 converter
// Converts a binary32 bit pattern to a binary16 bit pattern.
// ----------------------------------------------------------------------------
// Each request passes through three register stages, and one request is accepted
// per cycle while the output is not stalled.
// The pipeline advances whenever its last stage is empty or being taken, so
// backpressure stalls all stages together and nothing is lost or repeated.
module float32_to_float16 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] single_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] half_bits
);

  logic adv;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  f32f16_core u_core (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_vld      (in_valid),
    .single_bits (single_bits),
    .out_vld     (out_valid),
    .half_bits   (half_bits)
  );

endmodule

/* hdl/f32f16_core.sv */
// ----------------------------------------------------------------------------
// Float32 to float16 datapath
// Three register stages: classify, reduce mantissa, assemble result.
// ----------------------------------------------------------------------------
module f32f16_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_vld,
  input  logic [31:0] single_bits,
  output logic        out_vld,
  output logic [15:0] half_bits
);

  // Stage 1: class and fields.
  logic              s1_vld;
  f32f16_pkg::cls_t  s1_cls;
  logic              s1_sign;
  logic [7:0]        s1_exp;
  logic [22:0]       s1_mant;
  f32f16_pkg::cls_t  cls_next;

  always_comb begin
    priority if (single_bits[30:23] < 8'd103) begin
      cls_next = f32f16_pkg::CLS_ZERO;
    end else if (single_bits[30:23] < 8'd113) begin
      cls_next = f32f16_pkg::CLS_DENORM;
    end else if (single_bits[30:23] <= 8'd142) begin
      cls_next = f32f16_pkg::CLS_NORMAL;
    end else if (single_bits[30:23] != 8'd255) begin
      cls_next = f32f16_pkg::CLS_OVF;
    end else begin
      cls_next = f32f16_pkg::CLS_SPECIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_vld;
    end
    if (adv) begin
      s1_cls  <= cls_next;
      s1_sign <= single_bits[31];
      s1_exp  <= single_bits[30:23];
      s1_mant <= single_bits[22:0];
    end
  end

  // Stage 2: mantissa reduction and exponent base.
  logic              s2_vld;
  logic              s2_sign;
  logic [14:0]       s2_base;
  logic [10:0]       s2_add;
  logic [10:0]       rnd;
  logic [3:0]        bsh;
  logic [4:0]        msh;
  logic [14:0]       base_next;
  logic [10:0]       add_next;

  always_comb begin
    rnd = {1'b0, s1_mant[22:13]};
    if (s1_mant[12] && (s1_mant[22:13] != f32f16_pkg::MANT_SAT)) begin
      rnd = rnd + 11'd1;
    end
    bsh = 4'(8'd113 - s1_exp);
    msh = 5'(8'd126 - s1_exp);
    base_next = '0;
    add_next  = '0;
    unique case (s1_cls)
      f32f16_pkg::CLS_ZERO: begin
      end
      f32f16_pkg::CLS_DENORM: begin
        base_next = 15'(f32f16_pkg::HALF_ONE >> bsh);
        add_next  = 11'(s1_mant >> msh);
      end
      f32f16_pkg::CLS_NORMAL: begin
        base_next = {5'(s1_exp - 8'd112), 10'd0};
        add_next  = rnd;
      end
      f32f16_pkg::CLS_OVF: begin
        base_next = f32f16_pkg::HALF_INF[14:0];
      end
      f32f16_pkg::CLS_SPECIAL: begin
        base_next = f32f16_pkg::HALF_INF[14:0];
        add_next  = rnd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
    if (adv) begin
      s2_sign <= s1_sign;
      s2_base <= base_next;
      s2_add  <= add_next;
    end
  end

  // Stage 3: final add. The sum never exceeds 16 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= s2_vld;
    end
    if (adv) begin
      half_bits <= {s2_sign, 15'd0} + {1'b0, s2_base} + {5'd0, s2_add};
    end
  end

endmodule

/* hdl/f32f16_checker.sv */
// ----------------------------------------------------------------------------
// Float32 to float16 checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module f32f16_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] half_bits
);

  `CHK_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(half_bits), "Result changed while stalled.")
  `CHK_ASSERT(a_ready_free, clk, rst, out_ready |-> in_ready, "Input stalled while output is free.")
  `CHK_ASSERT(a_stall, clk, rst, out_valid && !out_ready |-> !in_ready, "Input taken during output stall.")
  `CHK_ASSERT_ALWAYS(a_rst, clk, $past(rst) |-> !out_valid, "Result valid after reset.")

endmodule

bind float32_to_float16 f32f16_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .half_bits (half_bits)
);

/* sim/float32_to_float16_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Float32 to float16 checker
// Watches both channels of the converter, predicts each half precision result
// from the accepted request and compares it with the returned result in order.
// ----------------------------------------------------------------------------
module float32_to_float16_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] single_bits,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] half_bits,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  logic [15:0] expected_half_q[$];

  function automatic logic [9:0] round_top_mant(logic [22:0] m);
    logic [10:0] r;
    logic [9:0]  q;
    r = m[22:12];
    q = r[10:1];
    if (r[0] && q < f32f16_pkg::MANT_SAT) q = q + 10'd1;
    return q;
  endfunction

  function automatic logic [15:0] convert_to_half(logic [31:0] b);
    logic [15:0] s;
    int          e;
    logic [22:0] m;
    logic [15:0] res;
    s = b[31] ? 16'h8000 : 16'h0000;
    e = int'(b[30:23]) - 127;
    m = b[22:0];
    if (e < -24) begin
      res = s;
    end else if (e < -14) begin
      res = (s | (f32f16_pkg::HALF_ONE >> (-e - 14))) + 16'(m >> (-e - 1));
    end else if (e <= 15) begin
      res = (s | 16'((e + 15) << 10)) + {6'd0, round_top_mant(m)};
    end else if (e < 128) begin
      res = s | f32f16_pkg::HALF_INF;
    end else begin
      res = (s | f32f16_pkg::HALF_INF) + {6'd0, round_top_mant(m)};
    end
    return res;
  endfunction

  assign pending = expected_half_q.size();

  always @(posedge clk) begin
    logic [15:0] exp_h;
    if (rst) begin
      fail_count <= 0;
      checked <= 0;
      expected_half_q.delete();
    end else begin
      if (in_valid && in_ready) expected_half_q.push_back(convert_to_half(single_bits));
      if (out_valid && out_ready) begin
        checked <= checked + 1;
        if (expected_half_q.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result %h", half_bits);
          fail_count <= fail_count + 1;
        end else begin
          exp_h = expected_half_q.pop_front();
          if (exp_h !== half_bits) begin
            if (fail_count < 10)
              $display("Mismatch: expected %h, actual %h", exp_h, half_bits);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* sim/float32_to_float16_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Float32 to float16 testbench
// Drives directed and random binary32 patterns into the converter with random
// gaps and backpressure and reports the checker's verdict.
// ----------------------------------------------------------------------------
module float32_to_float16_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] single_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] half_bits;
  int          fail_count;
  int          pending;
  int          checked;
  int          cycle_count = 0;
  logic [31:0] request_q[$];
  int          sent = 0;

  localparam int CYCLE_LIMIT = 400000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  float32_to_float16 dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .single_bits(single_bits), .out_valid(out_valid), .out_ready(out_ready),
    .half_bits(half_bits)
  );

  float32_to_float16_checker checker_i (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .single_bits(single_bits), .out_valid(out_valid), .out_ready(out_ready),
    .half_bits(half_bits), .fail_count(fail_count), .pending(pending),
    .checked(checked)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] random_single();
    logic [7:0] ex;
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) ex = 8'($urandom_range(127 - 26, 127 + 17));
    else if (r < 7) ex = 8'hFF;
    else if (r < 8) ex = 8'h00;
    else ex = 8'($urandom_range(0, 255));
    return {1'($urandom_range(0, 1)), ex, 23'($urandom)};
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("float32_to_float16_tb failed");
      $finish;
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall = stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  initial begin
    int gap;
    int phase_quiet;
    request_q = '{32'h00000000, 32'h80000000, 32'h007FFFFF, 32'h33000000,
                  32'h33FFFFFF, 32'hB3800001, 32'h387FFFFF, 32'h38000000,
                  32'h38800000, 32'h38FFFFFF, 32'h3F800000, 32'h3F801000,
                  32'h3F800FFF, 32'h3FFFF000, 32'h477FE000, 32'hC77FFFFF,
                  32'h47800000, 32'h7F7FFFFF, 32'h7F800000, 32'hFF800000,
                  32'h7F801000, 32'h7FC00000, 32'hFFFFFFFF, 32'h7F800FFF,
                  32'h55555555};
    repeat (1600) request_q.push_back(random_single());
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (sent < request_q.size()) begin
      phase_quiet = (sent / 200) % 3 == 1;
      gap = phase_quiet ? 0 : gap_len();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      single_bits <= request_q[sent];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sent = sent + 1;
      if (phase_quiet && sent < request_q.size()) begin
        single_bits <= request_q[sent];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent = sent + 1;
      end
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d requests covering zeros, denormals, normals, overflow,", sent);
    $display("infinities and NaNs; %0d results were checked.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("float32_to_float16_tb passed");
    end else begin
      $display("float32_to_float16_tb failed");
    end
    $finish;
  end

endmodule
